// File: hdl/tmr_pkg.sv
// Package for the terminated message receiver.
// Holds field widths, register indexes, end reasons and reset values.
// No dependencies; imported by tmr_match, terminated_message_receiver and the testbench files.
package tmr_pkg;

    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 10;
    localparam int IDLE_W       = 16;
    localparam int MARKER_W     = 64;
    localparam int MLEN_W       = 4;
    localparam int MARKER_BYTES = MARKER_W / BYTE_W;

    localparam int MARKER_MAX_DEF  = 8;
    localparam int BUFFER_SIZE     = 1024;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MARKER_BYTES  = 2'd0,
        CFG_MARKER_LENGTH = 2'd1,
        CFG_MAX_LENGTH    = 2'd2,
        CFG_IDLE_LIMIT    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REASON_NONE   = 2'd0,
        REASON_MARKER = 2'd1,
        REASON_FULL   = 2'd2,
        REASON_IDLE   = 2'd3
    } t_reason;

    localparam logic [MARKER_W-1:0] RST_MARKER_BYTES  = 64'd10;
    localparam logic [MLEN_W-1:0]   RST_MARKER_LENGTH = 4'd1;
    localparam logic [LEN_W-1:0]    RST_MAX_LENGTH    = 10'd1023;
    localparam logic [IDLE_W-1:0]   RST_IDLE_LIMIT    = 16'd1000;

    localparam logic [IDLE_W-1:0]   IDLE_SAT = {IDLE_W{1'b1}};

endpackage

// File: hdl/tmr_match.sv
// Stop marker compare for the terminated message receiver.
// Compares the newest history bytes with the configured marker, lane by lane.
// Depends on tmr_pkg.
module tmr_match
    import tmr_pkg::*;
#(
    parameter int MARKER_MAX = MARKER_MAX_DEF,
    localparam int LANES  = (MARKER_MAX < MARKER_BYTES) ? MARKER_MAX : MARKER_BYTES,
    localparam int HIST_W = LANES * BYTE_W
) (
    input  logic [HIST_W-1:0]   i_history,
    input  logic [MARKER_W-1:0] i_marker,
    input  logic [MLEN_W-1:0]   i_marker_len,
    input  logic [LEN_W-1:0]    i_count,
    output logic                o_match
);

    logic [MLEN_W-1:0] eff_len;
    logic [LANES-1:0]  lane_ok;

    // Clamp the marker length into one to the number of lanes
    always_comb begin
        if (i_marker_len == '0) begin
            eff_len = MLEN_W'(1);
        end else if (32'(i_marker_len) > LANES) begin
            eff_len = MLEN_W'(LANES);
        end else begin
            eff_len = i_marker_len;
        end
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            lane_ok[i] = (i >= 32'(eff_len)) ||
                         (i_history[i*BYTE_W +: BYTE_W] == i_marker[i*BYTE_W +: BYTE_W]);
        end
    end

    // No match until the message holds at least the whole marker
    assign o_match = (&lane_ok) && (i_count >= LEN_W'(eff_len));

endmodule

// File: hdl/terminated_message_receiver.sv
// Top level of the terminated message receiver.
// Holds the message state, configuration registers and output register.
// Depends on tmr_pkg and tmr_match.

// Takes one transaction per cycle, each a received byte or an idle poll, and
// answers in the next cycle: a byte gives one result with the running length,
// an idle poll gives a result only when it ends the message on timeout. The
// message ends when its last bytes equal the stop marker, when its length
// reaches the limit, or when the idle polls in a row reach the idle limit;
// the marker wins over the length limit. Each accepted item's result is loaded
// straight into the output register; the input is stalled only
// while that register holds a result the downstream side has not taken.
// Configuration writes are always accepted and must be made while idle.
module terminated_message_receiver
    import tmr_pkg::*;
#(
    parameter int MARKER_MAX = MARKER_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
    input  logic                 s_axis_tuser,   // [0] op
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,   // [7:0] out_byte, [17:8] length
    output logic                 m_axis_tlast,
    output logic [2:0]           m_axis_tuser,   // [0] has_byte, [2:1] end_reason
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MARKER_W-1:0]  i_cfg_data
);

    localparam int LANES  = (MARKER_MAX < MARKER_BYTES) ? MARKER_MAX : MARKER_BYTES;
    localparam int HIST_W = LANES * BYTE_W;

    // configuration
    logic [MARKER_W-1:0] r_marker;
    logic [MLEN_W-1:0]   r_marker_len;
    logic [LEN_W-1:0]    r_max_len;
    logic [IDLE_W-1:0]   r_idle_limit;

    // message state
    logic [HIST_W-1:0]   r_hist,  n_hist;
    logic [LEN_W-1:0]    r_count, n_count;
    logic [IDLE_W-1:0]   r_idle,  n_idle;

    // output register
    logic                r_out_valid;
    logic                r_has_byte, n_has_byte;
    logic [BYTE_W-1:0]   r_out_byte, n_out_byte;
    logic                r_last,     n_last;
    t_reason             r_reason,   n_reason;
    logic [LEN_W-1:0]    r_length,   n_length;
    logic                n_emit;

    logic                in_accept;
    logic                marker_hit;
    logic [HIST_W-1:0]   shift_hist;
    logic [LEN_W-1:0]    inc_count;
    logic [IDLE_W-1:0]   inc_idle;
    logic [LEN_W-1:0]    eff_limit;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign shift_hist = HIST_W'({r_hist, s_axis_tdata});
    assign inc_count  = r_count + LEN_W'(1);
    assign inc_idle   = (r_idle == IDLE_SAT) ? r_idle : r_idle + IDLE_W'(1);

    always_comb begin
        if (32'(r_max_len) > BUFFER_SIZE - 1) begin
            eff_limit = LEN_W'(BUFFER_SIZE - 1);
        end else begin
            eff_limit = r_max_len;
        end
    end

    tmr_match #(
        .MARKER_MAX (MARKER_MAX)
    ) u_match (
        .i_history    (shift_hist),
        .i_marker     (r_marker),
        .i_marker_len (r_marker_len),
        .i_count      (inc_count),
        .o_match      (marker_hit)
    );

    always_comb begin
        n_hist     = r_hist;
        n_count    = r_count;
        n_idle     = r_idle;
        n_emit     = 1'b0;
        n_has_byte = 1'b0;
        n_out_byte = '0;
        n_last     = 1'b0;
        n_reason   = REASON_NONE;
        n_length   = r_count;
        if (!s_axis_tuser) begin
            n_emit     = 1'b1;
            n_has_byte = 1'b1;
            n_out_byte = s_axis_tdata;
            n_length   = inc_count;
            if (marker_hit) begin
                n_reason = REASON_MARKER;
            end else if (inc_count >= eff_limit) begin
                n_reason = REASON_FULL;
            end
            n_last = (n_reason != REASON_NONE);
            if (n_last) begin
                n_hist  = '0;
                n_count = '0;
            end else begin
                n_hist  = shift_hist;
                n_count = inc_count;
            end
            n_idle = '0;
        end else begin
            n_idle = inc_idle;
            if (inc_idle >= r_idle_limit) begin
                n_emit   = 1'b1;
                n_last   = 1'b1;
                n_reason = REASON_IDLE;
                n_hist   = '0;
                n_count  = '0;
                n_idle   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker     <= RST_MARKER_BYTES;
            r_marker_len <= RST_MARKER_LENGTH;
            r_max_len    <= RST_MAX_LENGTH;
            r_idle_limit <= RST_IDLE_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MARKER_BYTES:  r_marker     <= i_cfg_data;
                CFG_MARKER_LENGTH: r_marker_len <= i_cfg_data[MLEN_W-1:0];
                CFG_MAX_LENGTH:    r_max_len    <= i_cfg_data[LEN_W-1:0];
                CFG_IDLE_LIMIT:    r_idle_limit <= i_cfg_data[IDLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist      <= '0;
            r_count     <= '0;
            r_idle      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_hist  <= n_hist;
                r_count <= n_count;
                r_idle  <= n_idle;
            end
            // Load a new result, or drop the old one once taken
            if (in_accept && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && n_emit) begin
            r_has_byte <= n_has_byte;
            r_out_byte <= n_out_byte;
            r_last     <= n_last;
            r_reason   <= n_reason;
            r_length   <= n_length;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_length, r_out_byte};
    assign m_axis_tlast  = r_last;
    assign m_axis_tuser  = {r_reason, r_has_byte};

endmodule

// File: tb/terminated_message_receiver_check.sv
`timescale 1ns / 1ps
// Result checker for the terminated message receiver: follows the configuration,
// input and result channels, predicts every result and compares it field by field.
// Depends on tmr_pkg; instantiated beside the block by terminated_message_receiver_test.
module terminated_message_receiver_check
    import tmr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [7:0]           i_s_tdata,    // [7:0] rx_byte
    input  logic                 i_s_tuser,    // [0] op
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [23:0]          i_m_tdata,    // [7:0] out_byte, [17:8] length
    input  logic                 i_m_tlast,
    input  logic [2:0]           i_m_tuser,    // [0] has_byte, [2:1] end_reason
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MARKER_W-1:0]  i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam logic OP_IDLE = 1'b1;

    typedef struct packed {
        logic             has_byte;
        logic [7:0]       out_byte;
        logic             last;
        t_reason          end_reason;
        logic [LEN_W-1:0] length;
    } frame_result_t;

    logic [MARKER_W-1:0] marker_q;
    logic [MLEN_W-1:0]   marker_len_q;
    logic [LEN_W-1:0]    max_len_q;
    logic [IDLE_W-1:0]   idle_limit_q;
    logic [MARKER_W-1:0] history_q;
    logic [LEN_W-1:0]    byte_cnt_q;
    logic [IDLE_W-1:0]   idle_cnt_q;
    frame_result_t       results_due[$];
    int                  fails = 0;

    task automatic clear_message();
        history_q  = '0;
        byte_cnt_q = '0;
        idle_cnt_q = '0;
    endtask

    task automatic frame_byte(input logic [7:0] b);
        int unsigned         span;
        int unsigned         limit;
        logic [MARKER_W-1:0] mask;
        frame_result_t       r;
        span = (marker_len_q == 0) ? 1 : marker_len_q;
        if (span > MARKER_MAX_DEF) span = MARKER_MAX_DEF;
        if (span > MARKER_BYTES) span = MARKER_BYTES;
        mask = (span >= MARKER_BYTES) ? '1 : ((64'd1 << (BYTE_W * span)) - 64'd1);
        limit = max_len_q;
        if (limit > BUFFER_SIZE - 1) limit = BUFFER_SIZE - 1;

        history_q  = {history_q[MARKER_W-BYTE_W-1:0], b};
        byte_cnt_q = byte_cnt_q + 1'b1;
        idle_cnt_q = '0;

        r.has_byte   = 1'b1;
        r.out_byte   = b;
        r.length     = byte_cnt_q;
        r.end_reason = REASON_NONE;
        // the marker takes precedence over the length limit
        if (byte_cnt_q >= span && (history_q & mask) == (marker_q & mask)) begin
            r.end_reason = REASON_MARKER;
        end else if (byte_cnt_q >= limit) begin
            r.end_reason = REASON_FULL;
        end
        r.last = (r.end_reason != REASON_NONE);
        results_due.push_back(r);
        if (r.last) clear_message();
    endtask

    task automatic frame_idle();
        frame_result_t r;
        if (idle_cnt_q != IDLE_SAT) idle_cnt_q = idle_cnt_q + 1'b1;
        if (idle_cnt_q >= idle_limit_q) begin
            r            = '0;
            r.last       = 1'b1;
            r.end_reason = REASON_IDLE;
            r.length     = byte_cnt_q;
            results_due.push_back(r);
            clear_message();
        end
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        frame_result_t want;
        if (!i_rst_n) begin
            marker_q     = RST_MARKER_BYTES;
            marker_len_q = RST_MARKER_LENGTH;
            max_len_q    = RST_MAX_LENGTH;
            idle_limit_q = RST_IDLE_LIMIT;
            clear_message();
            results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MARKER_BYTES:  marker_q     = i_cfg_data;
                    CFG_MARKER_LENGTH: marker_len_q = i_cfg_data[MLEN_W-1:0];
                    CFG_MAX_LENGTH:    max_len_q    = i_cfg_data[LEN_W-1:0];
                    CFG_IDLE_LIMIT:    idle_limit_q = i_cfg_data[IDLE_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == OP_IDLE) frame_idle();
                else frame_byte(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result: tdata 0x%0h, tuser 0x%0h, tlast %0b",
                           i_m_tdata, i_m_tuser, i_m_tlast);
                    fails++;
                end else begin
                    want = results_due.pop_front();
                    check_field("has_byte", want.has_byte, i_m_tuser[0]);
                    check_field("out_byte", want.out_byte, i_m_tdata[7:0]);
                    check_field("last", want.last, i_m_tlast);
                    check_field("end_reason", want.end_reason, i_m_tuser[2:1]);
                    check_field("length", want.length, i_m_tdata[17:8]);
                    check_field("tdata padding", 0, i_m_tdata[23:18]);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= results_due.size();
    end

endmodule

// File: tb/terminated_message_receiver_test.sv
`timescale 1ns / 1ps
// Test top for the terminated message receiver: clock, reset, configuration
// phases, directed and random stimulus, random back-pressure and the verdict.
// Depends on tmr_pkg, terminated_message_receiver and terminated_message_receiver_check.
module terminated_message_receiver_test;
    import tmr_pkg::*;

    localparam logic OP_BYTE      = 1'b0;
    localparam logic OP_IDLE      = 1'b1;
    localparam int   LONG_HOLD    = 400;
    localparam int   DRAIN_CYCLES = 4;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;        // [7:0] rx_byte
    logic                 s_axis_tuser  = OP_BYTE;   // [0] op
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;              // [7:0] out_byte, [17:8] length
    logic                 m_axis_tlast;
    logic [2:0]           m_axis_tuser;              // [0] has_byte, [2:1] end_reason
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = CFG_MARKER_BYTES;
    logic [MARKER_W-1:0]  i_cfg_data    = '0;

    int fail_count;
    int pending;
    int items_sent = 0;
    bit hold_req   = 1'b0;
    bit hold_done  = 1'b0;
    bit send_calm  = 1'b0;
    bit recv_calm  = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    terminated_message_receiver u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    terminated_message_receiver_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .i_m_tuser    (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Mostly short gaps, now and then a long one; none at all in a calm stretch.
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input logic op, input logic [7:0] b);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid, wait for every outstanding result, then let the block drain.
    task automatic settle_framer();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers back to back; junk above each narrower field must be ignored.
    task automatic reprogram(input logic [63:0] mk, input logic [3:0] ml,
                             input logic [9:0] mx, input logic [15:0] il);
        logic [MARKER_W-1:0] vals [4];
        t_cfg_idx order [4] = '{CFG_MARKER_BYTES, CFG_MARKER_LENGTH,
                                CFG_MAX_LENGTH, CFG_IDLE_LIMIT};
        settle_framer();
        vals[CFG_MARKER_BYTES]                 = mk;
        vals[CFG_MARKER_LENGTH]                = {$urandom, $urandom};
        vals[CFG_MARKER_LENGTH][MLEN_W-1:0]    = ml;
        vals[CFG_MAX_LENGTH]                   = {$urandom, $urandom};
        vals[CFG_MAX_LENGTH][LEN_W-1:0]        = mx;
        vals[CFG_IDLE_LIMIT]                   = {$urandom, $urandom};
        vals[CFG_IDLE_LIMIT][IDLE_W-1:0]       = il;
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= order[k];
            i_cfg_data  <= vals[order[k]];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [63:0] mk, input logic [3:0] ml,
                             input logic [9:0] mx, input logic [15:0] il,
                             input int n_items, input bit bytes_only);
        int start;
        int span;
        int cut;
        int run;
        int pick;
        reprogram(mk, ml, mx, il);
        span  = (ml == 0) ? 1 : ((ml > MARKER_BYTES) ? MARKER_BYTES : ml);
        start = items_sent;
        while (items_sent - start < n_items) begin
            pick = $urandom_range(0, 99);
            if (bytes_only || pick >= 65) begin
                repeat ($urandom_range(1, 6)) send_item(OP_BYTE, 8'($urandom));
            end else if (pick < 35) begin
                // whole marker, earliest character first
                for (int k = span - 1; k >= 0; k--) send_item(OP_BYTE, mk[8*k +: 8]);
            end else if (pick < 45) begin
                // leading part of the marker, then a stray byte
                cut = $urandom_range(0, span - 1);
                for (int k = span - 1; k > cut; k--) send_item(OP_BYTE, mk[8*k +: 8]);
                send_item(OP_BYTE, 8'($urandom));
            end else begin
                // idle run around the timeout when the limit is reachable
                run = (il <= 12) ? $urandom_range(0, int'(il) + 1) : $urandom_range(1, 8);
                repeat (run) send_item(OP_IDLE, 8'($urandom));
            end
        end
    endtask

    initial begin : receiver
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
                stall = pick_gap(recv_calm);
                m_axis_tready <= (stall == 0);
                if (stall > 0) stall--;
            end
        end
    end

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset settings: extremes of the byte, an ignored poll, newline marker
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_IDLE, 8'hFF);
        send_item(OP_BYTE, 8'h0A);

        // idle limit zero: timeout on an empty message, then after one byte
        reprogram(RST_MARKER_BYTES, RST_MARKER_LENGTH, RST_MAX_LENGTH, 16'd0);
        send_item(OP_IDLE, 8'h00);
        send_item(OP_BYTE, 8'h55);
        send_item(OP_IDLE, 8'hAA);

        // marker length zero acts as one; length limit zero fills on every byte,
        // and a marker on the same byte still wins
        reprogram(RST_MARKER_BYTES, 4'd0, 10'd0, RST_IDLE_LIMIT);
        send_item(OP_BYTE, 8'h33);
        send_item(OP_BYTE, 8'h0A);

        // marker length above the maximum saturates to eight characters
        reprogram(64'h0102030405060708, 4'hF, RST_MAX_LENGTH, RST_IDLE_LIMIT);
        for (int k = 1; k <= 8; k++) send_item(OP_BYTE, 8'(k));

        // marker not yet fully received: history alone would match here
        reprogram(64'h000000000000000B, 4'd2, 10'd2, RST_IDLE_LIMIT);
        send_item(OP_BYTE, 8'h0B);
        send_item(OP_BYTE, 8'h01);

        settle_framer();
        hold_req = 1'b1;
        run_phase(RST_MARKER_BYTES, RST_MARKER_LENGTH, RST_MAX_LENGTH, RST_IDLE_LIMIT, 80, 1'b0);
        repeat (5) begin
            run_phase({$urandom, $urandom}, 4'($urandom_range(0, 15)),
                      ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 2))
                                                  : 10'($urandom_range(3, 40)),
                      ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 1))
                                                  : 16'($urandom_range(2, 10)),
                      60, 1'b0);
        end
        run_phase('0, 4'hF, 10'd1, 16'd1, 40, 1'b0);
        run_phase('1, 4'd8, 10'd1023, 16'hFFFF, 40, 1'b0);
        // one long message that ends on the length limit
        run_phase({$urandom, $urandom}, 4'd8, 10'd400, 16'hFFFF, 420, 1'b1);

        settle_framer();
        if (fail_count == 0) begin
            $display("** terminated_message_receiver: PASSED **");
        end else begin
            $display("** terminated_message_receiver: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #8_000_000;
        $display("** terminated_message_receiver: FAILED **");
        $finish;
    end

endmodule
